// ===== hdl/rhc_pkg.sv =====
// Package for the RGB/HSV color converter: beat structs, pipeline stage
// structs, fixed-point constants and the one-bit restoring divider step.
// No dependencies.
package rhc_pkg;

  // Hue scale: sixteenths of a degree
  localparam logic [12:0] HueFull   = 13'd5760;
  localparam logic [12:0] HueSector = 13'd960;

  // Divider geometry: numerators below 2^27, divisors below 2^19,
  // every quotient below 2^10
  localparam int unsigned NumW     = 27;
  localparam int unsigned DenW     = 19;
  localparam int unsigned QuoW     = 10;
  localparam int unsigned DivSteps = QuoW;

  // Mode codes
  localparam logic ModeRgbToHsv = 1'b0;
  localparam logic ModeHsvToRgb = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [12:0] hue_in;
    logic [7:0]  sat_in;
    logic [7:0]  val_in;
  } rhc_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [12:0] hue_out;
    logic [7:0]  sat_out;
    logic [7:0]  val_out;
    logic        hue_undefined;
  } rhc_out_t;

  // Fields carried alongside the divider
  typedef struct packed {
    logic        mode;
    logic [7:0]  mx;
    logic        undef;
    logic [11:0] base;
    logic        neg;
    logic [2:0]  sector;
    logic [7:0]  v;
  } rhc_side_t;

  typedef struct packed {
    rhc_side_t   side;
    logic [7:0]  delta;
    logic [7:0]  mag;
    logic [15:0] vs;
    logic [9:0]  t;
  } rhc_p1_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } rhc_lane_t;

  typedef struct packed {
    rhc_side_t side;
    rhc_lane_t a;
    rhc_lane_t b;
  } rhc_div_t;

  // One restoring step: resolve quotient bit pos
  function automatic rhc_lane_t rhc_div_step(rhc_lane_t l, int unsigned pos);
    logic [NumW:0] shd;
    rhc_lane_t     r;
    r   = l;
    shd = (NumW+1)'(l.den) << pos;
    if ({1'b0, l.rem} >= shd) begin
      r.rem      = l.rem - shd[NumW-1:0];
      r.quo[pos] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rgb_hsv_color_converter.sv =====
// Top level of the RGB/HSV color converter: a 13-stage pipeline with two
// shared 10-step restoring divider lanes. Depends on rhc_pkg.
//
// Takes one pixel per clock while in_stall_o is low and returns one result
// beat per pixel, in order. out_valid_o rises when the pixel enters stage 12.
// Stage 0 finds max/min, sector and the v*s product; stage 1 builds
// numerators and divisors; stages 2..11 each resolve one quotient bit in both
// divider lanes (saturation and hue for RGB to HSV, chroma and X for HSV to
// RGB); stage 12 assembles the result in the output register. The ten divider
// steps set the latency. Each stage moves when the stage after it is empty or
// moving, so bubbles close up while the output is stalled and in_stall_o
// rises only when every stage holds a pixel.
module rgb_hsv_color_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rhc_pkg::rhc_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rhc_pkg::rhc_out_t out_o
);

  localparam int unsigned NumStages = rhc_pkg::DivSteps + 3;
  localparam int unsigned LastStage = NumStages - 1;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  rhc_pkg::rhc_p1_t  p1_d, p1_q;
  rhc_pkg::rhc_div_t p2_d, p2_q;
  rhc_pkg::rhc_div_t div_q [rhc_pkg::DivSteps];
  rhc_pkg::rhc_out_t out_d, out_q;

  // Advance chain: a stage moves when empty or when its successor moves
  always_comb begin
    adv[LastStage] = !vld_q[LastStage] || !out_stall_i;
    for (int k = LastStage - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[LastStage];
  assign out_o       = out_q;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: extremes, sector, v*s, hue fraction
  always_comb begin
    logic [7:0]  r, g, b, mx, mn, pos, neg;
    logic [12:0] hw, frac;
    logic [2:0]  sec;
    r = in_i.red_in;
    g = in_i.green_in;
    b = in_i.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    p1_d = '0;
    p1_d.side.mode = in_i.mode;
    p1_d.side.mx   = mx;
    p1_d.delta     = mx - mn;
    p1_d.side.undef = (mx == mn);
    // red wins ties, then green
    if (r == mx) begin
      p1_d.side.base = 12'd0;
      pos = g;
      neg = b;
    end else if (g == mx) begin
      p1_d.side.base = 12'd1920;
      pos = b;
      neg = r;
    end else begin
      p1_d.side.base = 12'd3840;
      pos = r;
      neg = g;
    end
    p1_d.side.neg = (pos < neg);
    p1_d.mag      = (pos >= neg) ? pos - neg : neg - pos;
    // reverse direction
    hw = (in_i.hue_in >= rhc_pkg::HueFull) ? in_i.hue_in - rhc_pkg::HueFull : in_i.hue_in;
    if      (hw >= 13'd4800) sec = 3'd5;
    else if (hw >= 13'd3840) sec = 3'd4;
    else if (hw >= 13'd2880) sec = 3'd3;
    else if (hw >= 13'd1920) sec = 3'd2;
    else if (hw >= 13'd960)  sec = 3'd1;
    else                     sec = 3'd0;
    frac = hw - 13'(sec) * rhc_pkg::HueSector;
    p1_d.side.sector = sec;
    p1_d.side.v      = in_i.val_in;
    p1_d.vs          = 16'(in_i.val_in) * 16'(in_i.sat_in);
    p1_d.t           = sec[0] ? 10'(rhc_pkg::HueSector - frac) : frac[9:0];
  end

  // Stage 1: numerators and divisors for both lanes
  always_comb begin
    p2_d      = '0;
    p2_d.side = p1_q.side;
    if (p1_q.side.mode == rhc_pkg::ModeRgbToHsv) begin
      p2_d.a.rem = 27'(p1_q.delta) * 27'd510 + 27'(p1_q.side.mx);
      p2_d.a.den = (p1_q.side.mx == 8'd0) ? 19'd1 : 19'({p1_q.side.mx, 1'b0});
      p2_d.b.rem = 27'(p1_q.mag) * 27'd1920 + 27'(p1_q.delta);
      p2_d.b.den = (p1_q.delta == 8'd0) ? 19'd1 : 19'({p1_q.delta, 1'b0});
    end else begin
      p2_d.a.rem = 27'({p1_q.vs, 1'b0}) + 27'd255;
      p2_d.a.den = 19'd510;
      p2_d.b.rem = ((27'(p1_q.vs) * 27'(p1_q.t)) << 1) + 27'd244800;
      p2_d.b.den = 19'd489600;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) p1_q <= p1_d;
    if (adv[1]) p2_q <= p2_d;
  end

  // Divider: one quotient bit per stage, MSB first
  for (genvar s = 0; s < rhc_pkg::DivSteps; s++) begin : g_div
    localparam int unsigned Pos = rhc_pkg::DivSteps - 1 - s;
    rhc_pkg::rhc_div_t prev, nxt;
    assign prev = (s == 0) ? p2_q : div_q[(s == 0) ? 0 : s-1];
    always_comb begin
      nxt      = prev;
      nxt.a    = rhc_pkg::rhc_div_step(prev.a, Pos);
      nxt.b    = rhc_pkg::rhc_div_step(prev.b, Pos);
    end
    always_ff @(posedge clk_i) begin
      if (adv[s+2]) div_q[s] <= nxt;
    end
  end

  // Final stage: hue wrap or channel placement
  always_comb begin
    rhc_pkg::rhc_div_t f;
    logic [9:0]  q;
    logic [7:0]  c, x, m, cm, xm;
    logic [12:0] bs;
    f  = div_q[rhc_pkg::DivSteps-1];
    q  = f.b.quo;
    bs = 13'(f.side.base);
    c  = f.a.quo[7:0];
    x  = f.b.quo[7:0];
    m  = f.side.v - c;
    cm = c + m;
    xm = x + m;
    out_d = '0;
    if (f.side.mode == rhc_pkg::ModeRgbToHsv) begin
      out_d.sat_out       = f.a.quo[7:0];
      out_d.val_out       = f.side.mx;
      out_d.hue_undefined = f.side.undef;
      if (f.side.undef) begin
        out_d.hue_out = 13'd0;
      end else if (!f.side.neg) begin
        out_d.hue_out = bs + 13'(q);
      end else if (13'(q) > bs) begin
        out_d.hue_out = bs + rhc_pkg::HueFull - 13'(q);
      end else begin
        out_d.hue_out = bs - 13'(q);
      end
    end else begin
      case (f.side.sector)
        3'd0: begin
          out_d.red_out = cm; out_d.green_out = xm; out_d.blue_out = m;
        end
        3'd1: begin
          out_d.red_out = xm; out_d.green_out = cm; out_d.blue_out = m;
        end
        3'd2: begin
          out_d.red_out = m; out_d.green_out = cm; out_d.blue_out = xm;
        end
        3'd3: begin
          out_d.red_out = m; out_d.green_out = xm; out_d.blue_out = cm;
        end
        3'd4: begin
          out_d.red_out = xm; out_d.green_out = m; out_d.blue_out = cm;
        end
        default: begin
          out_d.red_out = cm; out_d.green_out = m; out_d.blue_out = xm;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LastStage]) out_q <= out_d;
  end

  // Checks
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.hue_out < rhc_pkg::HueFull)
    else $error("hue out of range");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.hue_undefined) |-> (out_o.hue_out == 13'd0 &&
      out_o.sat_out == 8'd0))
    else $error("gray pixel with hue or saturation");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q && out_stall_i))
    else $error("input stalled with room in pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result lost");

endmodule
